>>> rtl/core/hjpl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hjpl_pkg;

  // Fixed field widths.
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned FIELD_W  = 32;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned EMIT_W   = 6;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned CFG_IDX_W = 2;

  // Marker for an empty slot.
  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  // Operation codes of an input item.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  // Status codes of a final result.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BEYOND   = 2'd1;
  localparam logic [1:0] STATUS_NO_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_SHIFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EARLY_BREAK = 2'd3;

  // Configuration reset values.
  localparam logic [31:0]        RST_HASH_FACTOR = 32'd0;
  localparam logic [SHIFT_W-1:0] RST_HASH_SHIFT  = 5'd22;
  localparam logic [CNT_W-1:0]   RST_SLOT_COUNT  = 11'd1024;

  typedef struct packed {
    logic              operation;
    logic [9:0]        slot_index;
    logic [KEY_W-1:0]  item_key;
    logic [FIELD_W-1:0] item_payload;
  } in_item_t;

  typedef struct packed {
    logic               is_match;
    logic [FIELD_W-1:0] build_payload;
    logic [FIELD_W-1:0] probe_payload;
    logic [CNT_W-1:0]   match_count;
    logic [1:0]         probe_status;
    logic               last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       clear_step;
    logic       load_wr;
    logic       probe_cap;
    logic       hash_calc;
    logic       walk_start;
    logic       walk_adv;
    logic       count_hit;
    logic       push_match;
    logic       push_final;
    logic [1:0] final_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic beyond;
    logic slot_empty;
    logic slot_hit;
    logic walk_last;
    logic emit_room;
    logic out_free;
    logic early_break;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/hjpl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hjpl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_op_i,
  output logic               in_ready_o,
  input  wire hjpl_pkg::sts_t sts_i,
  output hjpl_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_START,
    ST_WALK,
    ST_FINAL
  } state_e;

  state_e     state_q, state_d;
  logic       ready_q, ready_d;
  logic [1:0] status_q, status_d;
  logic       accept;

  assign accept     = in_valid_i & ready_q;
  assign in_ready_o = ready_q;

  // Next state, commands and the held final status.
  always_comb begin
    state_d  = state_q;
    ready_d  = ready_q;
    status_d = status_q;
    cmd_o    = '0;
    cmd_o.final_status = status_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
          ready_d = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_op_i == hjpl_pkg::OP_LOAD) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            cmd_o.probe_cap = 1'b1;
            ready_d = 1'b0;
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        cmd_o.hash_calc = 1'b1;
        state_d = ST_START;
      end
      ST_START: begin
        if (sts_i.beyond) begin
          status_d = hjpl_pkg::STATUS_BEYOND;
          state_d  = ST_FINAL;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.slot_empty) begin
          status_d = hjpl_pkg::STATUS_OK;
          state_d  = ST_FINAL;
        end else if (sts_i.slot_hit && sts_i.emit_room && !sts_i.out_free) begin
          // A match waits here until the result register frees up.
          state_d = ST_WALK;
        end else begin
          if (sts_i.slot_hit) begin
            cmd_o.count_hit  = 1'b1;
            cmd_o.push_match = sts_i.emit_room;
          end
          if (sts_i.slot_hit && sts_i.early_break) begin
            status_d = hjpl_pkg::STATUS_OK;
            state_d  = ST_FINAL;
          end else if (sts_i.walk_last) begin
            status_d = hjpl_pkg::STATUS_NO_EMPTY;
            state_d  = ST_FINAL;
          end else begin
            cmd_o.walk_adv = 1'b1;
          end
        end
      end
      ST_FINAL: begin
        if (sts_i.out_free) begin
          cmd_o.push_final = 1'b1;
          ready_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        ready_d = 1'b0;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ready_q  <= 1'b0;
      status_q <= hjpl_pkg::STATUS_OK;
    end else begin
      state_q  <= state_d;
      ready_q  <= ready_d;
      status_q <= status_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/hjpl_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module hjpl_dpath #(
  parameter int unsigned TABLE_SLOTS  = 1024,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned MAX_EMITTED  = 63
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic [hjpl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [31:0]                     cfg_data_i,
  input  wire hjpl_pkg::in_item_t              in_i,
  input  wire hjpl_pkg::cmd_t                  cmd_i,
  output hjpl_pkg::sts_t                       sts_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output hjpl_pkg::out_item_t                  out_o
);

  localparam int unsigned CNT_W   = hjpl_pkg::CNT_W;
  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam int unsigned SLOTS_W = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned LIM_W   = (SLOTS_W > CNT_W) ? SLOTS_W : CNT_W;

  // Configuration registers.
  logic [31:0]                     factor_q;
  logic [hjpl_pkg::SHIFT_W-1:0]    shift_q;
  logic [CNT_W-1:0]                slot_count_q;
  logic                            early_q;

  // Probe context.
  logic [hjpl_pkg::KEY_W-1:0]      key_q;
  logic [PAYLOAD_BITS-1:0]         probe_pay_q;
  logic [31:0]                     prod_q;
  logic [IDX_W-1:0]                pos_q;
  logic [CNT_W-1:0]                visited_q;
  logic [CNT_W-1:0]                count_q;
  logic [hjpl_pkg::EMIT_W-1:0]     emitted_q;
  logic [IDX_W-1:0]                clr_q;

  // Table stores and their registered read data.
  logic [hjpl_pkg::KEY_W-1:0]      key_mem [TABLE_SLOTS];
  logic [PAYLOAD_BITS-1:0]         pay_mem [TABLE_SLOTS];
  logic [hjpl_pkg::KEY_W-1:0]      key_rd_q;
  logic [PAYLOAD_BITS-1:0]         pay_rd_q;

  // Result register.
  logic                            out_valid_q;
  hjpl_pkg::out_item_t             out_q;

  logic [CNT_W-1:0]                lim;
  logic [31:0]                     hash;
  logic [LIM_W-1:0]                pos_inc;
  logic [IDX_W-1:0]                pos_nxt;
  logic [IDX_W-1:0]                rd_addr;
  logic                            rd_en;
  logic                            load_ok;
  logic                            key_we;
  logic [IDX_W-1:0]                wr_addr;
  logic [hjpl_pkg::KEY_W-1:0]      wr_key;
  logic                            out_free;

  // Slots in use, capped at the table size.
  always_comb begin
    if (LIM_W'(slot_count_q) > LIM_W'(TABLE_SLOTS)) begin
      lim = CNT_W'(TABLE_SLOTS);
    end else begin
      lim = slot_count_q;
    end
  end

  // Hash index, next probe position and read address.
  assign hash    = prod_q >> shift_q;
  assign pos_inc = LIM_W'(pos_q) + LIM_W'(1);
  assign pos_nxt = (pos_inc == LIM_W'(lim)) ? '0 : IDX_W'(pos_inc);
  assign rd_addr = cmd_i.walk_start ? IDX_W'(hash) : pos_nxt;
  assign rd_en   = cmd_i.walk_start | cmd_i.walk_adv;

  // Write port shared by the clearing pass and loads.
  assign load_ok = 32'(in_i.slot_index) < 32'(TABLE_SLOTS);
  assign key_we  = cmd_i.clear_step | (cmd_i.load_wr & load_ok);
  assign wr_addr = cmd_i.clear_step ? clr_q : IDX_W'(in_i.slot_index);
  assign wr_key  = cmd_i.clear_step ? hjpl_pkg::EMPTY_KEY : in_i.item_key;

  assign out_free = ~out_valid_q | out_ready_i;

  // Status toward the controller.
  always_comb begin
    sts_o.clear_last  = clr_q == IDX_W'(TABLE_SLOTS - 1);
    sts_o.beyond      = hash >= 32'(lim);
    sts_o.slot_empty  = key_rd_q == hjpl_pkg::EMPTY_KEY;
    sts_o.slot_hit    = key_rd_q == key_q;
    sts_o.walk_last   = (visited_q + 1'b1) == lim;
    sts_o.emit_room   = emitted_q < hjpl_pkg::EMIT_W'(MAX_EMITTED);
    sts_o.out_free    = out_free;
    sts_o.early_break = early_q;
  end

  // Key store.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_addr] <= wr_key;
    end
    if (rd_en) begin
      key_rd_q <= key_mem[rd_addr];
    end
  end

  // Build payload store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok) begin
      pay_mem[wr_addr] <= PAYLOAD_BITS'(in_i.item_payload);
    end
    if (rd_en) begin
      pay_rd_q <= pay_mem[rd_addr];
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q     <= hjpl_pkg::RST_HASH_FACTOR;
      shift_q      <= hjpl_pkg::RST_HASH_SHIFT;
      slot_count_q <= hjpl_pkg::RST_SLOT_COUNT;
      early_q      <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        hjpl_pkg::CFG_HASH_FACTOR: factor_q     <= cfg_data_i;
        hjpl_pkg::CFG_HASH_SHIFT:  shift_q      <= cfg_data_i[hjpl_pkg::SHIFT_W-1:0];
        hjpl_pkg::CFG_SLOT_COUNT:  slot_count_q <= cfg_data_i[CNT_W-1:0];
        hjpl_pkg::CFG_EARLY_BREAK: early_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Probe key, payload and hash product registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.probe_cap) begin
      key_q       <= in_i.item_key;
      probe_pay_q <= PAYLOAD_BITS'(in_i.item_payload);
    end
    if (cmd_i.hash_calc) begin
      prod_q <= key_q * factor_q;
    end
  end

  // Walk position, counters and the clearing pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      pos_q     <= '0;
      visited_q <= '0;
      count_q   <= '0;
      emitted_q <= '0;
    end else begin
      if (cmd_i.clear_step) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.probe_cap) begin
        count_q   <= '0;
        emitted_q <= '0;
      end
      if (cmd_i.walk_start) begin
        pos_q     <= IDX_W'(hash);
        visited_q <= '0;
      end else if (cmd_i.walk_adv) begin
        pos_q     <= pos_nxt;
        visited_q <= visited_q + 1'b1;
      end
      if (cmd_i.count_hit && count_q != hjpl_pkg::COUNT_MAX) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.push_match) begin
        emitted_q <= emitted_q + 1'b1;
      end
    end
  end

  // Result register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push_match || cmd_i.push_final) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_match) begin
      out_q.is_match      <= 1'b1;
      out_q.build_payload <= hjpl_pkg::FIELD_W'(pay_rd_q);
      out_q.probe_payload <= hjpl_pkg::FIELD_W'(probe_pay_q);
      out_q.match_count   <= '0;
      out_q.probe_status  <= hjpl_pkg::STATUS_OK;
      out_q.last          <= 1'b0;
    end else if (cmd_i.push_final) begin
      out_q.is_match      <= 1'b0;
      out_q.build_payload <= '0;
      out_q.probe_payload <= hjpl_pkg::FIELD_W'(probe_pay_q);
      out_q.match_count   <= count_q;
      out_q.probe_status  <= cmd_i.final_status;
      out_q.last          <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> rtl/core/hash_join_probe_linear_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake               | Payload
// --------+-----------+-------------------------+-----------------------------------
// in      | input     | in_valid_i / in_ready_o | in_i  (load a slot or probe a key)
// out     | output    | out_valid_o/out_ready_i | out_o (match results, then final)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// A load is written as it is taken and the input stays ready for the next item.
// A probe steps through taking the item, the multiply, the shift and range check, a walk of
// one read per slot through the single key-store read port (skipped when out of range), and
// the final result. After reset the key store is swept to empty slot by slot; no item is
// taken until the sweep ends. A stalled result register holds the walk at the next match
// or at the final result.
module hash_join_probe_linear_core #(
  parameter int unsigned TABLE_SLOTS  = 1024,
  parameter int unsigned PAYLOAD_BITS = 32,
  parameter int unsigned MAX_EMITTED  = 63
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [hjpl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                    cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire hjpl_pkg::in_item_t             in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output hjpl_pkg::out_item_t                 out_o
);

  hjpl_pkg::cmd_t cmd;
  hjpl_pkg::sts_t sts;

  // Registers accept a transfer on every cycle.
  assign cfg_ready_o = 1'b1;

  hjpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_i.operation),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hjpl_dpath #(
    .TABLE_SLOTS  (TABLE_SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .MAX_EMITTED  (MAX_EMITTED)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/hjpl_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hjpl_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire hjpl_pkg::in_item_t  in_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire hjpl_pkg::out_item_t out_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed while stalled");

  // Taking a probe drops the input ready, blocking further input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_i.operation == hjpl_pkg::OP_PROBE |=> !in_ready_o)
    else $error("input taken while a probe is in flight");

  // Every result is either a match or the final one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.last != out_o.is_match)
    else $error("result is neither match nor final");

  // Match results carry no count and no status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.is_match |->
      out_o.match_count == '0 && out_o.probe_status == hjpl_pkg::STATUS_OK)
    else $error("match result with count or status");

endmodule

bind hash_join_probe_linear_core hjpl_checker u_hjpl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_i        (in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

`default_nettype wire
